// ===== design/etc2_pkg.sv =====
// Shared types, constants and helper functions for the ETC2/EAC block decoder.
package etc2_pkg;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  typedef enum logic [2:0] {
    MODE_INDIV  = 3'd0,
    MODE_DIFF   = 3'd1,
    MODE_T      = 3'd2,
    MODE_H      = 3'd3,
    MODE_PLANAR = 3'd4
  } color_mode_t;

  // One classified block, as handed from front to back
  typedef struct packed {
    color_mode_t mode;
    logic [63:0] color_block;
    logic [63:0] alpha_block;
    logic        with_alpha;
    logic [7:0]  base0_r, base0_g, base0_b;
    logic [7:0]  base1_r, base1_g, base1_b;
    logic [6:0]  distance;
  } block_job_t;

  function automatic logic signed [3:0] delta3(input logic [2:0] c);
    return {c[2], c};
  endfunction

  function automatic logic [7:0] ex4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] ex5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] ex6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] ex7(input logic [6:0] v);
    return {v, v[6]};
  endfunction

  function automatic logic [6:0] dist_tab(input logic [2:0] i);
    logic [6:0] d;
    case (i)
      3'd0: d = 7'd3;
      3'd1: d = 7'd6;
      3'd2: d = 7'd11;
      3'd3: d = 7'd16;
      3'd4: d = 7'd23;
      3'd5: d = 7'd32;
      3'd6: d = 7'd41;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

  // Magnitudes of the ETC1 modifier table; index bit 1 gives the sign
  function automatic logic [7:0] etc_mag(input logic [2:0] t, input logic lg);
    logic [7:0] m;
    case ({t, lg})
      4'd0:  m = 8'd2;   4'd1:  m = 8'd8;
      4'd2:  m = 8'd5;   4'd3:  m = 8'd17;
      4'd4:  m = 8'd9;   4'd5:  m = 8'd29;
      4'd6:  m = 8'd13;  4'd7:  m = 8'd42;
      4'd8:  m = 8'd18;  4'd9:  m = 8'd60;
      4'd10: m = 8'd24;  4'd11: m = 8'd80;
      4'd12: m = 8'd33;  4'd13: m = 8'd106;
      4'd14: m = 8'd47;  default: m = 8'd183;
    endcase
    return m;
  endfunction

  // Full EAC table as individual signed entries
  function automatic logic signed [4:0] eac_tab(input logic [3:0] t, input logic [2:0] i);
    logic signed [4:0] v;
    logic [6:0] k;
    k = {t, i};
    case (k)
      7'd0: v=-3; 7'd1: v=-6; 7'd2: v=-9; 7'd3: v=-15; 7'd4: v=2; 7'd5: v=5; 7'd6: v=8;
      7'd7: v=14;
      7'd8: v=-3; 7'd9: v=-7; 7'd10: v=-10; 7'd11: v=-13; 7'd12: v=2; 7'd13: v=6;
      7'd14: v=9; 7'd15: v=12;
      7'd16: v=-2; 7'd17: v=-5; 7'd18: v=-8; 7'd19: v=-13; 7'd20: v=1; 7'd21: v=4;
      7'd22: v=7; 7'd23: v=12;
      7'd24: v=-2; 7'd25: v=-4; 7'd26: v=-6; 7'd27: v=-13; 7'd28: v=1; 7'd29: v=3;
      7'd30: v=5; 7'd31: v=12;
      7'd32: v=-3; 7'd33: v=-6; 7'd34: v=-8; 7'd35: v=-12; 7'd36: v=2; 7'd37: v=5;
      7'd38: v=7; 7'd39: v=11;
      7'd40: v=-3; 7'd41: v=-7; 7'd42: v=-9; 7'd43: v=-11; 7'd44: v=2; 7'd45: v=6;
      7'd46: v=8; 7'd47: v=10;
      7'd48: v=-4; 7'd49: v=-7; 7'd50: v=-8; 7'd51: v=-11; 7'd52: v=3; 7'd53: v=6;
      7'd54: v=7; 7'd55: v=10;
      7'd56: v=-3; 7'd57: v=-5; 7'd58: v=-8; 7'd59: v=-11; 7'd60: v=2; 7'd61: v=4;
      7'd62: v=7; 7'd63: v=10;
      7'd64: v=-2; 7'd65: v=-6; 7'd66: v=-8; 7'd67: v=-10; 7'd68: v=1; 7'd69: v=5;
      7'd70: v=7; 7'd71: v=9;
      7'd72: v=-2; 7'd73: v=-5; 7'd74: v=-8; 7'd75: v=-10; 7'd76: v=1; 7'd77: v=4;
      7'd78: v=7; 7'd79: v=9;
      7'd80: v=-2; 7'd81: v=-4; 7'd82: v=-8; 7'd83: v=-10; 7'd84: v=1; 7'd85: v=3;
      7'd86: v=7; 7'd87: v=9;
      7'd88: v=-2; 7'd89: v=-5; 7'd90: v=-7; 7'd91: v=-10; 7'd92: v=1; 7'd93: v=4;
      7'd94: v=6; 7'd95: v=9;
      7'd96: v=-3; 7'd97: v=-4; 7'd98: v=-7; 7'd99: v=-10; 7'd100: v=2; 7'd101: v=3;
      7'd102: v=6; 7'd103: v=9;
      7'd104: v=-1; 7'd105: v=-2; 7'd106: v=-3; 7'd107: v=-10; 7'd108: v=0; 7'd109: v=1;
      7'd110: v=2; 7'd111: v=9;
      7'd112: v=-4; 7'd113: v=-6; 7'd114: v=-8; 7'd115: v=-9; 7'd116: v=3; 7'd117: v=5;
      7'd118: v=7; 7'd119: v=8;
      7'd120: v=-3; 7'd121: v=-5; 7'd122: v=-7; 7'd123: v=-9; 7'd124: v=2; 7'd125: v=4;
      7'd126: v=6; default: v=8;
    endcase
    return v;
  endfunction

  // Clamp a signed 11-bit value to 0..255
  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 11'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

endpackage

// ===== design/etc2_front.sv =====
// Front end: accept a block pair, classify the colour mode, expand the base colours.
module etc2_front import etc2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] color_block,
  input  logic [63:0] alpha_block,
  input  logic        with_alpha,
  output logic        job_valid,
  input  logic        job_ready,
  output block_job_t  job
);

  logic signed [6:0] rs, gs, bs;
  logic rs_ov, gs_ov, bs_ov;
  block_job_t j;
  logic [23:0] v1, v2;
  logic [63:0] c;

  assign c = color_block;

  // Register slice: take a word whenever the slot is free or draining
  assign in_ready = !job_valid || job_ready;

  always_comb begin
    rs = 7'(signed'({2'b00, c[63:59]})) + 7'(delta3(c[58:56]));
    gs = 7'(signed'({2'b00, c[55:51]})) + 7'(delta3(c[50:48]));
    bs = 7'(signed'({2'b00, c[47:43]})) + 7'(delta3(c[42:40]));
    rs_ov = rs < 0 || rs > 7'sd31;
    gs_ov = gs < 0 || gs > 7'sd31;
    bs_ov = bs < 0 || bs > 7'sd31;
    j = '0;
    j.color_block = c;
    j.alpha_block = alpha_block;
    j.with_alpha  = with_alpha;
    v1 = '0;
    v2 = '0;
    if (!c[33]) begin
      j.mode = MODE_INDIV;
      j.base0_r = ex4(c[63:60]); j.base1_r = ex4(c[59:56]);
      j.base0_g = ex4(c[55:52]); j.base1_g = ex4(c[51:48]);
      j.base0_b = ex4(c[47:44]); j.base1_b = ex4(c[43:40]);
    end else if (rs_ov) begin
      j.mode = MODE_T;
      j.base0_r = ex4({c[60:59], c[57:56]});
      j.base0_g = ex4(c[55:52]);
      j.base0_b = ex4(c[51:48]);
      j.base1_r = ex4(c[47:44]);
      j.base1_g = ex4(c[43:40]);
      j.base1_b = ex4(c[39:36]);
      j.distance = dist_tab({c[35:34], c[32]});
    end else if (gs_ov) begin
      j.mode = MODE_H;
      j.base0_r = ex4(c[62:59]);
      j.base0_g = ex4({c[58:56], c[52]});
      j.base0_b = ex4({c[51], c[49:48], c[47]});
      j.base1_r = ex4(c[46:43]);
      j.base1_g = ex4(c[42:39]);
      j.base1_b = ex4(c[38:35]);
      v1 = {j.base0_r, j.base0_g, j.base0_b};
      v2 = {j.base1_r, j.base1_g, j.base1_b};
      j.distance = dist_tab({c[34], c[32], v1 >= v2});
    end else if (bs_ov) begin
      j.mode = MODE_PLANAR;
    end else begin
      j.mode = MODE_DIFF;
      j.base0_r = ex5(c[63:59]); j.base1_r = ex5(rs[4:0]);
      j.base0_g = ex5(c[55:51]); j.base1_g = ex5(gs[4:0]);
      j.base0_b = ex5(c[47:43]); j.base1_b = ex5(bs[4:0]);
    end
  end

  // Hold the classified job until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      job <= j;
    end
  end

endmodule

// ===== design/etc2_queue.sv =====
// Two-entry job queue between the front and back ends.
module etc2_queue import etc2_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  block_job_t wr_job,
  output logic       rd_valid,
  input  logic       rd_ready,
  output block_job_t rd_job
);

  block_job_t mem [QueueDepth];
  logic [QueuePtrW-1:0] wp, rp;
  logic [QueuePtrW:0]   cnt;
  logic wr, rd;

  assign wr_ready = cnt != (QueuePtrW+1)'(QueueDepth);
  assign rd_valid = cnt != '0;
  assign rd_job   = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (QueuePtrW+1)'(wr) - (QueuePtrW+1)'(rd);
    end
    if (wr) mem[wp] <= wr_job;
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) cnt <= (QueuePtrW+1)'(QueueDepth);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overfilled");

  property p_count_up;
    @(posedge clk) disable iff (rst) (wr && !rd) |=> cnt == $past(cnt) + 1'b1;
  endproperty
  a_count_up: assert property (p_count_up) else $error("queue count lost a write");

  property p_count_down;
    @(posedge clk) disable iff (rst) (rd && !wr) |=> cnt == $past(cnt) - 1'b1;
  endproperty
  a_count_down: assert property (p_count_down) else $error("queue count lost a read");

endmodule

// ===== design/etc2_back.sv =====
// Back end: walk the sixteen texels of a job and register each decoded texel.
module etc2_back import etc2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  block_job_t  job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  pixel_x,
  output logic [1:0]  pixel_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [2:0]  color_mode,
  output logic        last
);

  logic [3:0] idx;
  logic       adv;
  logic [1:0] x, y;
  logic [63:0] c, a;
  logic [1:0] pi;
  logic       sub;
  logic [7:0] mag;
  logic signed [10:0] m;
  logic [7:0] r_n, g_n, b_n, a_n;
  logic [5:0] sh;
  logic signed [4:0] am;
  logic signed [10:0] av;

  function automatic logic [7:0] plane(input logic [7:0] o, input logic [7:0] h,
                                       input logic [7:0] v, input logic [1:0] px,
                                       input logic [1:0] py);
    logic signed [12:0] s;
    s = 13'(signed'({1'b0, px})) * (13'(h) - 13'(o))
      + 13'(signed'({1'b0, py})) * (13'(v) - 13'(o))
      + 13'(o) * 13'sd4 + 13'sd2;
    return clamp8(11'(s >>> 2));
  endfunction

  function automatic logic [7:0] tri_sel(input logic [1:0] p, input logic [7:0] b0,
                                         input logic [7:0] b1, input logic [6:0] d,
                                         input logic is_t);
    logic signed [10:0] s0, s1;
    s0 = 11'(b0); s1 = 11'(b1);
    if (is_t) begin
      case (p)
        2'd0: return b0;
        2'd1: return clamp8(s1 + 11'(d));
        2'd2: return b1;
        default: return clamp8(s1 - 11'(d));
      endcase
    end
    case (p)
      2'd0: return clamp8(s0 + 11'(d));
      2'd1: return clamp8(s0 - 11'(d));
      2'd2: return clamp8(s1 + 11'(d));
      default: return clamp8(s1 - 11'(d));
    endcase
  endfunction

  assign c = job.color_block;
  assign a = job.alpha_block;
  assign x = idx[3:2];
  assign y = idx[1:0];
  assign adv = job_valid && (!out_valid || out_ready);
  assign job_ready = adv && idx == 4'd15;

  always_comb begin
    pi  = {c[16 + 32'(idx)], c[32'(idx)]};
    sub = c[32] ? y[1] : x[1];
    mag = etc_mag(sub ? c[36:34] : c[39:37], pi[0]);
    m   = pi[1] ? -11'(mag) : 11'(mag);
    r_n = '0; g_n = '0; b_n = '0;
    case (job.mode)
      MODE_INDIV, MODE_DIFF: begin
        r_n = clamp8(11'(sub ? job.base1_r : job.base0_r) + m);
        g_n = clamp8(11'(sub ? job.base1_g : job.base0_g) + m);
        b_n = clamp8(11'(sub ? job.base1_b : job.base0_b) + m);
      end
      MODE_PLANAR: begin
        r_n = plane(ex6(c[62:57]), ex6({c[38:34], c[32]}), ex6(c[18:13]), x, y);
        g_n = plane(ex7({c[56], c[54:49]}), ex7(c[31:25]), ex7(c[12:6]), x, y);
        b_n = plane(ex6({c[48], c[44:43], c[41:39]}), ex6(c[24:19]), ex6(c[5:0]), x, y);
      end
      default: begin
        r_n = tri_sel(pi, job.base0_r, job.base1_r, job.distance, job.mode == MODE_T);
        g_n = tri_sel(pi, job.base0_g, job.base1_g, job.distance, job.mode == MODE_T);
        b_n = tri_sel(pi, job.base0_b, job.base1_b, job.distance, job.mode == MODE_T);
      end
    endcase
    sh = 6'(6'd45 - 6'd3 * 6'(idx));
    am = eac_tab(a[51:48], a[sh +: 3]);
    av = 11'(a[63:56]) + 11'(am) * 11'(a[55:52]);
    a_n = job.with_alpha ? clamp8(av) : 8'd255;
  end

  // Advance one texel per accepted output slot and register it
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) idx <= idx + 1'b1;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (adv) begin
      pixel_x    <= x;
      pixel_y    <= y;
      red        <= r_n;
      green      <= g_n;
      blue       <= b_n;
      alpha      <= a_n;
      color_mode <= job.mode;
      last       <= idx == 4'd15;
    end
  end

  property p_stall_holds;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> $stable(idx);
  endproperty
  a_stall_holds: assert property (p_stall_holds) else $error("texel counter moved in stall");

  property p_last_pos;
    @(posedge clk) disable iff (rst) (out_valid && last) |-> (pixel_x == 2'd3 && pixel_y == 2'd3);
  endproperty
  a_last_pos: assert property (p_last_pos) else $error("last flag on wrong texel");

  property p_mode_legal;
    @(posedge clk) disable iff (rst) out_valid |-> color_mode <= 3'd4;
  endproperty
  a_mode_legal: assert property (p_mode_legal) else $error("bad colour mode");

endmodule

// ===== design/etc2_eac_block_decoder.sv =====
// Top level of the ETC2 RGB8 / RGBA8 (EAC alpha) 4x4 block decoder.
// Usage:
//  s_axis carries one word per block: colour block and alpha block.
//  m_axis gives sixteen texel words per block, column-major (x outer, y inner),
//  tlast on the sixteenth texel.
//  cfg_valid/cfg_ready writes with_alpha (bit 0); write it only while idle.
//  The first texel passes the front register, a queue entry and the output
//  register, in that order, after the block word is taken.
//  Throughput: one texel per cycle while a job is queued and tready is high,
//  set by the back end's texel counter that feeds the single output register.
//  The front end and the two-entry queue take further blocks while the back
//  end is still emitting texels.
//  Reset clears the queue, the texel counter, valid flags and with_alpha.
//  When the receiver holds tready low the current texel is held and the
//  counter stops; the queue then fills and s_axis_tready drops.
module etc2_eac_block_decoder import etc2_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // color_block[63:0], alpha_block[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // pixel_x, pixel_y, red, green, blue, alpha
  output logic [2:0]   m_axis_tuser,   // color_mode
  output logic         m_axis_tlast
);

  logic       with_alpha;
  logic       fj_valid, fj_ready, bj_valid, bj_ready;
  block_job_t fjob, bjob;
  logic [1:0] px, py;
  logic [7:0] r, g, b, al;

  assign cfg_ready = 1'b1;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) with_alpha <= 1'b0;
    else if (cfg_valid) with_alpha <= cfg_data;
  end

  etc2_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .color_block(s_axis_tdata[63:0]), .alpha_block(s_axis_tdata[127:64]),
    .with_alpha,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
  );

  etc2_queue u_queue (
    .clk, .rst,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fjob),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bjob)
  );

  etc2_back u_back (
    .clk, .rst,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .pixel_x(px), .pixel_y(py), .red(r), .green(g), .blue(b), .alpha(al),
    .color_mode(m_axis_tuser), .last(m_axis_tlast)
  );

  assign m_axis_tdata = {al, b, g, r, py, px, 4'b0000} >> 4;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ETC2/EAC 4x4 block decoder.
`timescale 1ns / 1ps

module tb;
  import etc2_pkg::*;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // color_block, alpha_block
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;   // pixel_x, pixel_y, red, green, blue, alpha
  logic [2:0]   m_axis_tuser;   // color_mode
  logic         m_axis_tlast;

  typedef struct {
    logic [1:0]  px;
    logic [1:0]  py;
    logic [7:0]  r, g, b, a;
    color_mode_t mode;
    logic        last;
  } texel_t;

  texel_t texel_q[$];
  bit     alpha_on;
  int     fail_count;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_stall_pct;

  etc2_eac_block_decoder dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("etc2_eac_block_decoder regression: fail");
      $finish;
    end
  end

  function automatic int clip8(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic int etc_modifier(int t, int idx);
    int mags[16] = '{2, 8, 5, 17, 9, 29, 13, 42, 18, 60, 24, 80, 33, 106, 47, 183};
    int m;
    m = mags[t * 2 + (idx & 1)];
    return (idx & 2) ? -m : m;
  endfunction

  function automatic int eac_modifier(int t, int i);
    int tabv[128] = '{
      -3, -6, -9, -15, 2, 5, 8, 14,   -3, -7, -10, -13, 2, 6, 9, 12,
      -2, -5, -8, -13, 1, 4, 7, 12,   -2, -4, -6, -13, 1, 3, 5, 12,
      -3, -6, -8, -12, 2, 5, 7, 11,   -3, -7, -9, -11, 2, 6, 8, 10,
      -4, -7, -8, -11, 3, 6, 7, 10,   -3, -5, -8, -11, 2, 4, 7, 10,
      -2, -6, -8, -10, 1, 5, 7, 9,    -2, -5, -8, -10, 1, 4, 7, 9,
      -2, -4, -8, -10, 1, 3, 7, 9,    -2, -5, -7, -10, 1, 4, 6, 9,
      -3, -4, -7, -10, 2, 3, 6, 9,    -1, -2, -3, -10, 0, 1, 2, 9,
      -4, -6, -8, -9, 3, 5, 7, 8,     -3, -5, -7, -9, 2, 4, 6, 8};
    return tabv[t * 8 + i];
  endfunction

  function automatic int sext3(logic [2:0] d);
    return d[2] ? int'(d) - 8 : int'(d);
  endfunction

  function automatic int planar_px(int o, int h, int v, int x, int y);
    int s;
    s = x * (h - o) + y * (v - o) + 4 * o + 2;
    return clip8((s + 1024) / 4 - 256);
  endfunction

  function automatic int dup4(int v); return v * 17; endfunction
  function automatic int dup5(int v); return (v << 3) | (v >> 2); endfunction
  function automatic int dup6(int v); return (v << 2) | (v >> 4); endfunction
  function automatic int dup7(int v); return (v << 1) | (v >> 6); endfunction

  // Work out the sixteen texels of one block and queue them
  task automatic decode_block(logic [63:0] c, logic [63:0] a);
    int base[2][3];
    int paint[4][3];
    int rs, gs, bs, d, sub, m, idx, x, y, ch, al, sel;
    int o[3], h[3], v[3];
    color_mode_t mode;
    texel_t t;
    rs = c[63:59] + sext3(c[58:56]);
    gs = c[55:51] + sext3(c[50:48]);
    bs = c[47:43] + sext3(c[42:40]);
    base = '{default: 0};
    paint = '{default: 0};
    o = '{0, 0, 0}; h = '{0, 0, 0}; v = '{0, 0, 0};
    if (!c[33]) begin
      mode = MODE_INDIV;
      for (ch = 0; ch < 3; ch++) begin
        base[0][ch] = dup4(c[63 - 8 * ch -: 4]);
        base[1][ch] = dup4(c[59 - 8 * ch -: 4]);
      end
    end else if (rs < 0 || rs > 31) begin
      mode = MODE_T;
      base[0] = '{dup4({c[60:59], c[57:56]}), dup4(c[55:52]), dup4(c[51:48])};
      base[1] = '{dup4(c[47:44]), dup4(c[43:40]), dup4(c[39:36])};
      d = dist_tab({c[35:34], c[32]});
      for (ch = 0; ch < 3; ch++) begin
        paint[0][ch] = base[0][ch];
        paint[1][ch] = clip8(base[1][ch] + d);
        paint[2][ch] = base[1][ch];
        paint[3][ch] = clip8(base[1][ch] - d);
      end
    end else if (gs < 0 || gs > 31) begin
      mode = MODE_H;
      base[0] = '{dup4(c[62:59]), dup4({c[58:56], c[52]}),
                  dup4({c[51], c[49:48], c[47]})};
      base[1] = '{dup4(c[46:43]), dup4(c[42:39]), dup4(c[38:35])};
      sel = ((base[0][0] << 16) | (base[0][1] << 8) | base[0][2]) >=
            ((base[1][0] << 16) | (base[1][1] << 8) | base[1][2]);
      d = dist_tab({c[34], c[32], sel[0]});
      for (ch = 0; ch < 3; ch++) begin
        paint[0][ch] = clip8(base[0][ch] + d);
        paint[1][ch] = clip8(base[0][ch] - d);
        paint[2][ch] = clip8(base[1][ch] + d);
        paint[3][ch] = clip8(base[1][ch] - d);
      end
    end else if (bs < 0 || bs > 31) begin
      mode = MODE_PLANAR;
      o = '{dup6(c[62:57]), dup7({c[56], c[54:49]}), dup6({c[48], c[44:43], c[41:39]})};
      h = '{dup6({c[38:34], c[32]}), dup7(c[31:25]), dup6(c[24:19])};
      v = '{dup6(c[18:13]), dup7(c[12:6]), dup6(c[5:0])};
    end else begin
      mode = MODE_DIFF;
      base[0] = '{dup5(c[63:59]), dup5(c[55:51]), dup5(c[47:43])};
      base[1] = '{dup5(rs), dup5(gs), dup5(bs)};
    end
    for (int i = 0; i < 16; i++) begin
      x = i >> 2;
      y = i & 3;
      idx = int'({c[16 + i], c[i]});
      t.px = x[1:0];
      t.py = y[1:0];
      t.mode = mode;
      t.last = (i == 15);
      if (mode == MODE_INDIV || mode == MODE_DIFF) begin
        sub = c[32] ? (y >= 2) : (x >= 2);
        m = etc_modifier(sub ? int'(c[36:34]) : int'(c[39:37]), idx);
        t.r = 8'(clip8(base[sub][0] + m));
        t.g = 8'(clip8(base[sub][1] + m));
        t.b = 8'(clip8(base[sub][2] + m));
      end else if (mode == MODE_PLANAR) begin
        t.r = 8'(planar_px(o[0], h[0], v[0], x, y));
        t.g = 8'(planar_px(o[1], h[1], v[1], x, y));
        t.b = 8'(planar_px(o[2], h[2], v[2], x, y));
      end else begin
        t.r = 8'(paint[idx][0]);
        t.g = 8'(paint[idx][1]);
        t.b = 8'(paint[idx][2]);
      end
      al = 255;
      if (alpha_on)
        al = clip8(a[63:56] + eac_modifier(a[51:48], a[(15 - i) * 3 +: 3]) * a[55:52]);
      t.a = 8'(al);
      texel_q.push_back(t);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Compare every accepted texel word with the oldest expectation
  always @(posedge clk) begin
    texel_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (texel_q.size() == 0) begin
        $display("unexpected texel word");
        fail_count++;
      end else begin
        w = texel_q.pop_front();
        if (m_axis_tdata[1:0] != w.px) report_mismatch("pixel_x", m_axis_tdata[1:0], w.px);
        if (m_axis_tdata[3:2] != w.py) report_mismatch("pixel_y", m_axis_tdata[3:2], w.py);
        if (m_axis_tdata[11:4] != w.r) report_mismatch("red", m_axis_tdata[11:4], w.r);
        if (m_axis_tdata[19:12] != w.g) report_mismatch("green", m_axis_tdata[19:12], w.g);
        if (m_axis_tdata[27:20] != w.b) report_mismatch("blue", m_axis_tdata[27:20], w.b);
        if (m_axis_tdata[35:28] != w.a) report_mismatch("alpha", m_axis_tdata[35:28], w.a);
        if (m_axis_tuser != w.mode) report_mismatch("color_mode", m_axis_tuser, w.mode);
        if (m_axis_tlast != w.last) report_mismatch("last", m_axis_tlast, w.last);
        if (m_axis_tdata[39:36] != 4'd0) report_mismatch("pad", m_axis_tdata[39:36], 0);
      end
    end
  end

  // Stall the receiver at the set rate
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one block word, idling first at the set rate; valid drops only while idling
  task automatic send_block(logic [63:0] c, logic [63:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {a, c};
    decode_block(c, a);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_alpha_enable(bit en);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_on = en;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Force a chosen mode by shaping the diff bit and the delta overflows
  function automatic logic [63:0] shape_block(int want);
    logic [63:0] c;
    c = rand64();
    if (want == 0) begin
      c[33] = 1'b0;
      return c;
    end
    c[33] = 1'b1;
    if (want == 2) begin
      c[63:59] = 5'd31; c[58:56] = 3'(1 + $urandom_range(2));
      return c;
    end
    c[63:59] = 5'($urandom_range(4, 28)); c[58:56] = 3'($urandom_range(7));
    if (c[58:56] inside {3'd0, 3'd1, 3'd2, 3'd3}) c[63:59] = 5'($urandom_range(0, 28));
    if (want == 3) begin
      c[55:51] = 5'd0; c[50:48] = 3'(4 + $urandom_range(3));
      return c;
    end
    c[55:51] = 5'($urandom_range(4, 27)); c[50:48] = 3'($urandom_range(7));
    if (want == 4) begin
      c[47:43] = 5'd31; c[42:40] = 3'(1 + $urandom_range(2));
      return c;
    end
    c[47:43] = 5'($urandom_range(4, 27)); c[42:40] = 3'($urandom_range(7));
    return c;
  endfunction

  task automatic test_directed;
    send_block(64'h0, 64'h0);
    send_block(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_block(64'hffff_fffd_ffff_ffff, 64'h0);
    send_block(64'h0000_0002_0000_0000, 64'hff0f_0000_0000_0000);
    send_block(64'hffff_ffff_0000_0000, 64'h00f0_0000_0000_0000);
    send_block(64'hf800_0003_ffff_0000, 64'h80ff_ffff_ffff_ffff);
    send_block(64'h04fc_0002_0000_ffff, 64'h7f0d_4924_9249_2492);
    send_block(64'hfefe_fefe_fefe_fefe, 64'h0000_ffff_0000_ffff);
    for (int mo = 0; mo < 5; mo++)
      for (int k = 0; k < 3; k++) send_block(shape_block(mo), rand64());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) send_block(shape_block($urandom_range(4)), rand64());
      else send_block(rand64(), rand64());
    end
  endtask

  task automatic test_phase(int idle, int stall, bit en, int n);
    write_alpha_enable(en);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random(n);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    alpha_on = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_alpha_enable(1'b1);
    test_directed();
    test_phase(0, 0, 1'b1, 50);
    test_phase(84, 0, 1'b0, 40);
    test_phase(0, 84, 1'b1, 40);
    test_phase(16, 16, 1'b0, 30);
    test_phase(16, 16, 1'b1, 25);
    drain();
    if (fail_count == 0) $display("etc2_eac_block_decoder regression: pass");
    else $display("etc2_eac_block_decoder regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/etc2_pkg.sv
design/etc2_front.sv
design/etc2_queue.sv
design/etc2_back.sv
design/etc2_eac_block_decoder.sv
tb/sv/tb.sv
